@@ hw/rtl/ipd_pkg.sv @@
// Package for the phase delay evaluator: widths, constants, command and status types.
// Holds the CORDIC arctangent table and small helpers used by the datapath module.
// No dependencies.
package ipd_pkg;

    localparam int NUM_TAPS_DEF     = 3;
    localparam int CORDIC_ITERS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int IDX_W            = 5;
    localparam int CNT_W            = 6;
    localparam int ACC_W            = 52;
    localparam int Z_W              = 34;
    localparam int DIV_W            = 32;
    localparam int DIVR_STEPS       = 32;
    localparam int DIVD_STEPS       = 27;
    localparam int FREQ_W           = 18;
    localparam int COEF_W           = 16;
    localparam int DELAY_W          = 27;
    localparam int CFG_IDX_W        = 3;

    localparam logic [31:0] CORDIC_START = 32'd652032874;

    localparam logic [CFG_IDX_W-1:0] REG_B0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A0    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A1    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_A2    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SRATE = 3'd7;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_DIVR, S_TAP, S_SC, S_MUL, S_GAIN, S_VLOAD, S_VZERO,
        S_VNORM, S_VPRE, S_VITER, S_VSTORE, S_PHASE, S_PMUL, S_DIVD_INIT, S_DIVD,
        S_FINISH
    } ctrl_state_t;

    typedef enum logic [3:0] {
        DP_NOP, DP_LOAD, DP_DIV_INIT_R, DP_DIV_STEP, DP_SC_INIT, DP_SC_STEP, DP_MUL,
        DP_GAIN, DP_V_LOAD, DP_V_NORM, DP_V_PRE, DP_V_STEP, DP_V_STORE, DP_PHASE,
        DP_PMUL, DP_DIV_INIT_D
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        logic             out_load;
        logic [1:0]       sel;
        logic [1:0]       tap;
        logic [IDX_W-1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic in_range;
        logic vec_zero;
        logic norm_ok;
    } dp_stat_t;

    function automatic logic [31:0] atan_turn(input logic [IDX_W-1:0] k);
        logic [31:0] v;
        case (k)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic [ACC_W-1:0] mag_acc(input logic signed [ACC_W-1:0] v);
        return v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    endfunction

endpackage

@@ hw/rtl/ipd_ctrl.sv @@
// Sequencer of the phase delay evaluator: handshakes, step counters and datapath commands.
// Depends on ipd_pkg.
module ipd_ctrl
    import ipd_pkg::*;
#(
    parameter int NUM_TAPS     = NUM_TAPS_DEF,
    parameter int CORDIC_ITERS = CORDIC_ITERS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       tap_reg, tap_next;
    logic [1:0]       sel_reg, sel_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            tap_reg       <= '0;
            sel_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            tap_reg       <= tap_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        tap_next       = tap_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '{op: DP_NOP, out_load: 1'b0, sel: sel_reg, tap: tap_reg,
                           idx: cnt_reg[IDX_W-1:0]};
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cnt_next = '0;
                if (stat.in_range)
                begin
                    cmd.op     = DP_DIV_INIT_R;
                    state_next = S_DIVR;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_DIVR:
            begin
                cmd.op = DP_DIV_STEP;
                if (cnt_reg == CNT_W'(DIVR_STEPS - 1))
                begin
                    tap_next   = '0;
                    state_next = S_TAP;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_TAP:
            begin
                cmd.op     = DP_SC_INIT;
                cnt_next   = '0;
                state_next = S_SC;
            end
            S_SC:
            begin
                cmd.op = DP_SC_STEP;
                if (cnt_reg == CNT_W'(CORDIC_ITERS - 1))
                begin
                    sel_next   = '0;
                    state_next = S_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_MUL:
            begin
                cmd.op   = DP_MUL;
                sel_next = sel_reg + 1'b1;
                if (sel_reg == 2'd3)
                begin
                    if (tap_reg == 2'(NUM_TAPS - 1))
                    begin
                        state_next = S_GAIN;
                    end
                    else
                    begin
                        tap_next   = tap_reg + 1'b1;
                        state_next = S_TAP;
                    end
                end
            end
            S_GAIN:
            begin
                cmd.op     = DP_GAIN;
                sel_next   = '0;
                state_next = S_VLOAD;
            end
            S_VLOAD:
            begin
                cmd.op     = DP_V_LOAD;
                state_next = S_VZERO;
            end
            S_VZERO:
            begin
                state_next = stat.vec_zero ? S_VSTORE : S_VNORM;
            end
            S_VNORM:
            begin
                if (stat.norm_ok)
                begin
                    state_next = S_VPRE;
                end
                else
                begin
                    cmd.op = DP_V_NORM;
                end
            end
            S_VPRE:
            begin
                cmd.op     = DP_V_PRE;
                cnt_next   = '0;
                state_next = S_VITER;
            end
            S_VITER:
            begin
                cmd.op = DP_V_STEP;
                if (cnt_reg == CNT_W'(CORDIC_ITERS - 1))
                begin
                    state_next = S_VSTORE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_VSTORE:
            begin
                cmd.op = DP_V_STORE;
                if (!sel_reg[0])
                begin
                    sel_next   = 2'd1;
                    state_next = S_VLOAD;
                end
                else
                begin
                    state_next = S_PHASE;
                end
            end
            S_PHASE:
            begin
                cmd.op     = DP_PHASE;
                state_next = S_PMUL;
            end
            S_PMUL:
            begin
                cmd.op     = DP_PMUL;
                state_next = S_DIVD_INIT;
            end
            S_DIVD_INIT:
            begin
                cmd.op     = DP_DIV_INIT_D;
                cnt_next   = '0;
                state_next = S_DIVD;
            end
            S_DIVD:
            begin
                cmd.op = DP_DIV_STEP;
                if (cnt_reg == CNT_W'(DIVD_STEPS - 1))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ hw/rtl/ipd_datapath.sv @@
// Datapath of the phase delay evaluator: serial divider, shared CORDIC, multiplier, accumulators.
// Executes one command per cycle from ipd_ctrl. Depends on ipd_pkg.
module ipd_datapath
    import ipd_pkg::*;
(
    input  logic                            clk,
    input  dp_cmd_t                         cmd,
    output dp_stat_t                        stat,
    input  logic [FREQ_W-1:0]               query_freq,
    input  logic [2:0][COEF_W-1:0]          b_coef,
    input  logic [2:0][COEF_W-1:0]          a_coef,
    input  logic [COEF_W-1:0]               gain,
    input  logic [FREQ_W-1:0]               sample_rate,
    output logic signed [DELAY_W-1:0]       phase_delay,
    output logic                            freq_valid
);

    logic [FREQ_W-1:0]        f_reg, f_next;
    logic [FREQ_W-1:0]        div_reg, div_next;
    logic [FREQ_W-1:0]        rem_reg, rem_next;
    logic [DIV_W-1:0]         num_reg, num_next;
    logic [DIV_W-1:0]         q_reg, q_next;
    logic [31:0]              ang_reg, ang_next;
    logic                     flip_reg, flip_next;
    logic signed [ACC_W-1:0]  x_reg, x_next, y_reg, y_next;
    logic signed [Z_W-1:0]    z_reg, z_next;
    logic [ACC_W-1:0]         m_reg, m_next;
    logic signed [ACC_W-1:0]  nre_reg, nre_next, nim_reg, nim_next;
    logic signed [ACC_W-1:0]  dre_reg, dre_next, dim_reg, dim_next;
    logic signed [Z_W-1:0]    pn_reg, pn_next, pd_reg, pd_next, ph_reg, ph_next;
    logic signed [ACC_W-1:0]  prod_reg, prod_next;
    logic                     neg_reg, neg_next;
    logic signed [DELAY_W-1:0] phase_delay_reg, phase_delay_next;
    logic                     freq_valid_reg, freq_valid_next;

    logic [FREQ_W:0]          div_try;
    logic                     div_ge;
    logic signed [Z_W-1:0]    atan_z;
    logic signed [ACC_W-1:0]  sx, sy, cs_c, cs_s;
    logic signed [COEF_W-1:0] mul_a;
    logic signed [Z_W-1:0]    mul_b;
    logic signed [COEF_W+Z_W-1:0] mul_p;
    logic signed [ACC_W-1:0]  mul_ext;
    logic signed [Z_W:0]      ph_diff;
    logic signed [Z_W+FREQ_W:0] pm;
    logic [ACC_W-1:0]         prod_mag;
    logic [31:0]              ang_fold;
    logic                     fold;
    logic [DELAY_W:0]         qq;
    logic signed [DELAY_W-1:0] sat_d;

    function automatic logic ang_plus_quarter(input logic [31:0] a);
        logic [31:0] t;
        t = a + 32'h4000_0000;
        return t[31];
    endfunction

    assign stat.in_range = (f_reg != '0) && ({f_reg, 1'b0} <= {1'b0, sample_rate});
    assign stat.vec_zero = (x_reg == '0) && (y_reg == '0);
    assign stat.norm_ok  = (m_reg[ACC_W-1:41] == '0) && m_reg[40];

    always_comb
    begin
        div_try  = {rem_reg, num_reg[DIV_W-1]};
        div_ge   = (div_try >= {1'b0, div_reg});
        atan_z   = $signed({2'b00, atan_turn(cmd.idx)});
        sx       = x_reg >>> cmd.idx;
        sy       = y_reg >>> cmd.idx;
        cs_c     = flip_reg ? -x_reg : x_reg;
        cs_s     = flip_reg ? -y_reg : y_reg;
        mul_a    = cmd.sel[1] ? $signed(a_coef[cmd.tap]) : $signed(b_coef[cmd.tap]);
        mul_b    = cmd.sel[0] ? cs_s[Z_W-1:0] : cs_c[Z_W-1:0];
        mul_p    = mul_a * mul_b;
        mul_ext  = {{(ACC_W-COEF_W-Z_W){mul_p[COEF_W+Z_W-1]}}, mul_p};
        ph_diff  = {pd_reg[Z_W-1], pd_reg} - {pn_reg[Z_W-1], pn_reg};
        pm       = ph_reg * $signed({1'b0, sample_rate});
        prod_mag = mag_acc(prod_reg);
        fold     = ang_plus_quarter(ang_reg);
        ang_fold = fold ? {~ang_reg[31], ang_reg[30:0]} : ang_reg;
        qq       = {1'b0, q_reg[DELAY_W-1:0]};
        if (!neg_reg)
        begin
            sat_d = (qq[DELAY_W:DELAY_W-1] != '0) ? {1'b0, {(DELAY_W-1){1'b1}}}
                                                 : $signed(qq[DELAY_W-1:0]);
        end
        else
        begin
            sat_d = (qq > {2'b01, {(DELAY_W-1){1'b0}}}) ? {1'b1, {(DELAY_W-1){1'b0}}}
                                                        : $signed(DELAY_W'(-qq));
        end
    end

    always_comb
    begin
        f_next           = f_reg;
        div_next         = div_reg;
        rem_next         = rem_reg;
        num_next         = num_reg;
        q_next           = q_reg;
        ang_next         = ang_reg;
        flip_next        = flip_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        z_next           = z_reg;
        m_next           = m_reg;
        nre_next         = nre_reg;
        nim_next         = nim_reg;
        dre_next         = dre_reg;
        dim_next         = dim_reg;
        pn_next          = pn_reg;
        pd_next          = pd_reg;
        ph_next          = ph_reg;
        prod_next        = prod_reg;
        neg_next         = neg_reg;
        phase_delay_next = phase_delay_reg;
        freq_valid_next  = freq_valid_reg;
        unique case (cmd.op)
            DP_NOP:
            begin
            end
            DP_LOAD:
            begin
                f_next   = query_freq;
                ang_next = '0;
                nre_next = '0;
                nim_next = '0;
                dre_next = '0;
                dim_next = '0;
            end
            DP_DIV_INIT_R:
            begin
                rem_next = f_reg;
                div_next = sample_rate;
                num_next = '0;
            end
            DP_DIV_STEP:
            begin
                rem_next = div_ge ? FREQ_W'(div_try - {1'b0, div_reg}) : div_try[FREQ_W-1:0];
                num_next = {num_reg[DIV_W-2:0], 1'b0};
                q_next   = {q_reg[DIV_W-2:0], div_ge};
            end
            DP_SC_INIT:
            begin
                flip_next = fold;
                x_next    = ACC_W'(CORDIC_START);
                y_next    = '0;
                z_next    = {{(Z_W-32){ang_fold[31]}}, ang_fold};
            end
            DP_SC_STEP:
            begin
                if (!z_reg[Z_W-1])
                begin
                    x_next = x_reg - sy;
                    y_next = y_reg + sx;
                    z_next = z_reg - atan_z;
                end
                else
                begin
                    x_next = x_reg + sy;
                    y_next = y_reg - sx;
                    z_next = z_reg + atan_z;
                end
            end
            DP_MUL:
            begin
                case (cmd.sel)
                    2'd0:    nre_next = nre_reg + mul_ext;
                    2'd1:    nim_next = nim_reg - mul_ext;
                    2'd2:    dre_next = dre_reg + mul_ext;
                    default:
                    begin
                        dim_next = dim_reg - mul_ext;
                        ang_next = ang_reg + q_reg;
                    end
                endcase
            end
            DP_GAIN:
            begin
                if (gain[COEF_W-1])
                begin
                    nre_next = -nre_reg;
                    nim_next = -nim_reg;
                end
                else if (gain == '0)
                begin
                    nre_next = '0;
                    nim_next = '0;
                end
            end
            DP_V_LOAD:
            begin
                x_next = cmd.sel[0] ? dre_reg : nre_reg;
                y_next = cmd.sel[0] ? dim_reg : nim_reg;
                m_next = cmd.sel[0] ? ((mag_acc(dre_reg) > mag_acc(dim_reg)) ?
                                       mag_acc(dre_reg) : mag_acc(dim_reg))
                                    : ((mag_acc(nre_reg) > mag_acc(nim_reg)) ?
                                       mag_acc(nre_reg) : mag_acc(nim_reg));
                z_next = '0;
            end
            DP_V_NORM:
            begin
                if (m_reg[ACC_W-1:41] != '0)
                begin
                    x_next = x_reg >>> 1;
                    y_next = y_reg >>> 1;
                    m_next = m_reg >> 1;
                end
                else
                begin
                    x_next = x_reg <<< 1;
                    y_next = y_reg <<< 1;
                    m_next = m_reg << 1;
                end
            end
            DP_V_PRE:
            begin
                if (x_reg[ACC_W-1])
                begin
                    z_next = y_reg[ACC_W-1] ? -$signed(Z_W'(64'h8000_0000))
                                            : $signed(Z_W'(64'h8000_0000));
                    x_next = -x_reg;
                    y_next = -y_reg;
                end
            end
            DP_V_STEP:
            begin
                if (!y_reg[ACC_W-1] && (y_reg != '0))
                begin
                    x_next = x_reg + sy;
                    y_next = y_reg - sx;
                    z_next = z_reg + atan_z;
                end
                else
                begin
                    x_next = x_reg - sy;
                    y_next = y_reg + sx;
                    z_next = z_reg - atan_z;
                end
            end
            DP_V_STORE:
            begin
                if (cmd.sel[0])
                begin
                    pd_next = z_reg;
                end
                else
                begin
                    pn_next = z_reg;
                end
            end
            DP_PHASE:
            begin
                if (ph_diff >= $signed((Z_W+1)'(64'h1_0000_0000)))
                begin
                    ph_next = Z_W'(ph_diff - $signed((Z_W+1)'(64'h1_0000_0000)));
                end
                else if (ph_diff <= -$signed((Z_W+1)'(64'h1_0000_0000)))
                begin
                    ph_next = Z_W'(ph_diff + $signed((Z_W+1)'(64'h1_0000_0000)));
                end
                else
                begin
                    ph_next = Z_W'(ph_diff);
                end
            end
            DP_PMUL:
            begin
                prod_next = pm[ACC_W-1:0];
            end
            DP_DIV_INIT_D:
            begin
                neg_next = prod_reg[ACC_W-1];
                rem_next = '0;
                div_next = f_reg;
                num_next = {prod_mag[DELAY_W+23:24], {(DIV_W-DELAY_W){1'b0}}};
            end
            default:
            begin
            end
        endcase
        if (cmd.out_load)
        begin
            freq_valid_next  = stat.in_range;
            phase_delay_next = stat.in_range ? sat_d : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg           <= f_next;
        div_reg         <= div_next;
        rem_reg         <= rem_next;
        num_reg         <= num_next;
        q_reg           <= q_next;
        ang_reg         <= ang_next;
        flip_reg        <= flip_next;
        x_reg           <= x_next;
        y_reg           <= y_next;
        z_reg           <= z_next;
        m_reg           <= m_next;
        nre_reg         <= nre_next;
        nim_reg         <= nim_next;
        dre_reg         <= dre_next;
        dim_reg         <= dim_next;
        pn_reg          <= pn_next;
        pd_reg          <= pd_next;
        ph_reg          <= ph_next;
        prod_reg        <= prod_next;
        neg_reg         <= neg_next;
        phase_delay_reg <= phase_delay_next;
        freq_valid_reg  <= freq_valid_next;
    end

    assign phase_delay = phase_delay_reg;
    assign freq_valid  = freq_valid_reg;

endmodule

@@ hw/rtl/iir_phase_delay_eval.sv @@
// Top level of the filter phase delay evaluator: configuration registers, sequencer, datapath.
// Depends on ipd_pkg, ipd_ctrl and ipd_datapath.
//
// Usage:
//   Configuration: write b_coef0..2, a_coef0..2, gain and sample_rate through cfg_we,
//   cfg_index and cfg_data while the block is idle. Reset loads unity numerator and
//   denominator, unity gain and 48000 Hz.
//   Input channel: query_freq with in_valid/in_stall. One word is taken at a time; in_stall
//   stays high from the accept until the result is placed in the output register.
//   Output channel: phase_delay (Q18.8 samples) and freq_valid with out_valid/out_stall.
//   A frequency of zero or above half the sample rate gives a zero delay, freq_valid low.
//   An in-range query runs the reciprocal division, NUM_TAPS CORDIC rotations with their
//   products, the gain step, then for numerator and denominator a vector load, up to 40
//   normalization shifts, CORDIC_ITERS vectoring iterations and a store; a zero vector
//   skips normalization and iteration. Phase difference, product and division follow.
//   An out-of-range query goes straight to the output. The serial divider (32 and 27
//   steps) and the CORDIC unit are shared between these steps; one query is in flight at a time.
//   If the receiver stalls, the result holds in the output register; the next query is
//   accepted meanwhile and its result waits until the register is taken.
//   Reset clears the sequencer and the output valid flag.
module iir_phase_delay_eval
    import ipd_pkg::*;
#(
    parameter int NUM_TAPS     = NUM_TAPS_DEF,
    parameter int CORDIC_ITERS = CORDIC_ITERS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [FREQ_W-1:0]         cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [FREQ_W-1:0]         query_freq,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [DELAY_W-1:0] phase_delay,
    output logic                      freq_valid
);

    logic [2:0][COEF_W-1:0] b_coef_reg, b_coef_next;
    logic [2:0][COEF_W-1:0] a_coef_reg, a_coef_next;
    logic [COEF_W-1:0]      gain_reg, gain_next;
    logic [FREQ_W-1:0]      sample_rate_reg, sample_rate_next;
    dp_cmd_t                cmd;
    dp_stat_t               stat;

    always_comb
    begin
        b_coef_next      = b_coef_reg;
        a_coef_next      = a_coef_reg;
        gain_next        = gain_reg;
        sample_rate_next = sample_rate_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_B0:    b_coef_next[0]   = cfg_data[COEF_W-1:0];
                REG_B1:    b_coef_next[1]   = cfg_data[COEF_W-1:0];
                REG_B2:    b_coef_next[2]   = cfg_data[COEF_W-1:0];
                REG_A0:    a_coef_next[0]   = cfg_data[COEF_W-1:0];
                REG_A1:    a_coef_next[1]   = cfg_data[COEF_W-1:0];
                REG_A2:    a_coef_next[2]   = cfg_data[COEF_W-1:0];
                REG_GAIN:  gain_next        = cfg_data[COEF_W-1:0];
                REG_SRATE: sample_rate_next = cfg_data;
                default:   gain_next        = gain_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_coef_reg      <= {16'd0, 16'd0, 16'd16384};
            a_coef_reg      <= {16'd0, 16'd0, 16'd16384};
            gain_reg        <= 16'd4096;
            sample_rate_reg <= 18'd48000;
        end
        else
        begin
            b_coef_reg      <= b_coef_next;
            a_coef_reg      <= a_coef_next;
            gain_reg        <= gain_next;
            sample_rate_reg <= sample_rate_next;
        end
    end

    ipd_ctrl #(
        .NUM_TAPS     (NUM_TAPS),
        .CORDIC_ITERS (CORDIC_ITERS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    ipd_datapath u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .stat        (stat),
        .query_freq  (query_freq),
        .b_coef      (b_coef_reg),
        .a_coef      (a_coef_reg),
        .gain        (gain_reg),
        .sample_rate (sample_rate_reg),
        .phase_delay (phase_delay),
        .freq_valid  (freq_valid)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not held off after accept");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared right after accept");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !freq_valid |-> phase_delay == '0)
        else $error("nonzero delay for out-of-range frequency");
`endif

endmodule

@@ tb/tb_iir_phase_delay_eval.sv @@
// Testbench for iir_phase_delay_eval: directed and random frequency queries over several
// coefficient, gain and sample-rate settings, each result checked against a local predictor.
// Depends on ipd_pkg and the iir_phase_delay_eval RTL.
module tb_iir_phase_delay_eval
    import ipd_pkg::*;
();

    localparam int  N_TAPS      = 3;
    localparam int  N_ITERS     = 16;
    localparam longint TURN     = 64'sd1 <<< 32;
    localparam longint HALFTURN = 64'sd1 <<< 31;
    localparam int  RUN_LIMIT   = 1500000;

    localparam longint ATAN_TBL [0:15] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    typedef struct {
        logic signed [DELAY_W-1:0] delay;
        logic                      in_band;
    } delay_word_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [FREQ_W-1:0]         cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic [FREQ_W-1:0]         query_freq;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [DELAY_W-1:0] phase_delay;
    logic                      freq_valid;

    logic [FREQ_W-1:0] filt_regs [0:7];
    delay_word_t       expected_delays [$];
    int                errors;
    int                cycles;
    int                hold_cnt;
    int                max_wait;
    bit                long_hold;

    iir_phase_delay_eval uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .query_freq (query_freq),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .phase_delay(phase_delay),
        .freq_valid (freq_valid)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void cordic_sincos(input logic [31:0] ang, output longint c,
                                          output longint s);
        logic [31:0] a;
        logic [31:0] t;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        a = ang;
        t = a + 32'h40000000;
        if (t[31])
            a = a - 32'h80000000;
        z = longint'({32'b0, a});
        if (a[31])
            z = z - TURN;
        x = 652032874;
        y = 0;
        for (int k = 0; k < N_ITERS; k++)
        begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - ATAN_TBL[k];
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + ATAN_TBL[k];
            end
        end
        c = t[31] ? -x : x;
        s = t[31] ? -y : y;
    endfunction

    function automatic longint abs_val(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint vector_angle(input longint xi, input longint yi);
        longint x;
        longint y;
        longint z;
        longint m;
        longint dx;
        longint dy;
        x = xi;
        y = yi;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        m = (abs_val(x) > abs_val(y)) ? abs_val(x) : abs_val(y);
        while (m >= (64'sd1 <<< 41))
        begin
            x = x >>> 1; y = y >>> 1; m = m >>> 1;
        end
        while (m < (64'sd1 <<< 40))
        begin
            x = x * 2; y = y * 2; m = m * 2;
        end
        if (x < 0)
        begin
            z = (y >= 0) ? HALFTURN : -HALFTURN;
            x = -x;
            y = -y;
        end
        for (int k = 0; k < N_ITERS; k++)
        begin
            dx = y >>> k;
            dy = x >>> k;
            if (y > 0)
            begin
                x = x + dx; y = y - dy; z = z + ATAN_TBL[k];
            end
            else
            begin
                x = x - dx; y = y + dy; z = z - ATAN_TBL[k];
            end
        end
        return z;
    endfunction

    function automatic delay_word_t calc_phase_delay(input logic [FREQ_W-1:0] freq);
        delay_word_t       w;
        longint            f;
        longint            fs;
        longint unsigned   step;
        longint            nre, nim, dre, dim, c, s, bc, ac, g, pn, pd, ph, d;
        logic [31:0]       ang;
        f = longint'({46'b0, freq});
        fs = longint'({46'b0, filt_regs[REG_SRATE]});
        w.delay = '0;
        w.in_band = 1'b0;
        if (f == 0 || 2 * f > fs)
            return w;
        step = (longint'(f) <<< 32) / fs;
        nre = 0; nim = 0; dre = 0; dim = 0;
        for (int i = 0; i < N_TAPS; i++)
        begin
            bc = longint'($signed(filt_regs[REG_B0 + i][15:0]));
            ac = longint'($signed(filt_regs[REG_A0 + i][15:0]));
            ang = 32'(longint'(i) * step);
            cordic_sincos(ang, c, s);
            nre = nre + bc * c; nim = nim - bc * s;
            dre = dre + ac * c; dim = dim - ac * s;
        end
        g = longint'($signed(filt_regs[REG_GAIN][15:0]));
        if (g < 0)
        begin
            nre = -nre; nim = -nim;
        end
        else if (g == 0)
        begin
            nre = 0; nim = 0;
        end
        pn = vector_angle(nre, nim);
        pd = vector_angle(dre, dim);
        ph = (pd - pn) % TURN;
        d = (ph * fs) / (f * 16777216);
        if (d > 67108863)
            d = 67108863;
        if (d < -67108864)
            d = -67108864;
        w.delay = DELAY_W'(d);
        w.in_band = 1'b1;
        return w;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        delay_word_t w;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_cnt = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_delays.size() == 0)
                begin
                    $error("unexpected result word: phase_delay %0d", phase_delay);
                    errors++;
                end
                else
                begin
                    w = expected_delays.pop_front();
                    if (phase_delay !== w.delay)
                    begin
                        $error("phase_delay expected %0d actual %0d", w.delay, phase_delay);
                        errors++;
                    end
                    if (freq_valid !== w.in_band)
                    begin
                        $error("freq_valid expected %0d actual %0d", w.in_band, freq_valid);
                        errors++;
                    end
                end
                hold_cnt = $urandom_range(0, max_wait);
            end
            if (long_hold)
            begin
                hold_cnt = 1500;
                long_hold = 1'b0;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        logic [FREQ_W-1:0] v;
        v = FREQ_W'(val);
        if (idx != REG_SRATE)
            v[FREQ_W-1:16] = '0;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= FREQ_W'(val);
        filt_regs[idx] = v;
        @(posedge clk);
    endtask

    task automatic set_filter(input int b0, input int b1, input int b2, input int a0,
                              input int a1, input int a2, input int g, input int fs);
        write_reg(REG_B0, b0);
        write_reg(REG_B1, b1);
        write_reg(REG_B2, b2);
        write_reg(REG_A0, a0);
        write_reg(REG_A1, a1);
        write_reg(REG_A2, a2);
        write_reg(REG_GAIN, g);
        write_reg(REG_SRATE, fs);
        cfg_we <= 1'b0;
    endtask

    task automatic send_query(input logic [FREQ_W-1:0] f);
        int gap;
        gap = $urandom_range(0, max_wait);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            query_freq <= FREQ_W'($urandom);
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        query_freq <= f;
        expected_delays.push_back(calc_phase_delay(f));
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_delays.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    function automatic int pick_coef();
        case ($urandom_range(0, 5))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    function automatic int pick_rate();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(1, 64);
            1:       return 192000;
            2:       return 262143;
            default: return $urandom_range(8000, 192000);
        endcase
    endfunction

    function automatic logic [FREQ_W-1:0] pick_freq();
        int fs;
        fs = filt_regs[REG_SRATE];
        if ($urandom_range(0, 9) < 8 && fs >= 2)
            return FREQ_W'($urandom_range(1, fs / 2));
        return FREQ_W'($urandom);
    endfunction

    task automatic test_reset_values();
        send_query(0);
        send_query(1);
        send_query(24000);
        send_query(24001);
        send_query(18'h3FFFF);
        drain_results();
    endtask

    task automatic test_extremes();
        set_filter(32767, -32768, 32767, -32768, 32767, -32768, -32768, 262143);
        send_query(1);
        send_query(131071);
        send_query(131072);
        send_query(18'h2AAAA);
        drain_results();
        set_filter(0, 0, 0, 16384, -16384, 8192, 4096, 1);
        send_query(1);
        drain_results();
        set_filter(0, 0, 0, 0, 0, 0, 32767, 0);
        send_query(1);
        send_query(100);
        drain_results();
        set_filter(16384, 8000, -9000, 16384, -20000, 12000, 0, 2);
        send_query(1);
        send_query(2);
        drain_results();
        set_filter(-16384, 16384, 0, 16384, 0, -16384, -1, 192000);
        send_query(96000);
        send_query(1);
        send_query(48000);
        send_query(18'h15555);
        drain_results();
    endtask

    task automatic test_random(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++)
        begin
            set_filter(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                       pick_coef(), pick_coef(), pick_rate());
            max_wait = (p % 4 == 3) ? 0 : 8;
            for (int n = 0; n < per_phase; n++)
                send_query(pick_freq());
            drain_results();
        end
        max_wait = 8;
    endtask

    task automatic test_backpressure();
        set_filter(16384, -12000, 5000, 16384, -25000, 11000, 4096, 48000);
        long_hold = 1'b1;
        for (int n = 0; n < 20; n++)
            send_query(pick_freq());
        drain_results();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        query_freq = '0;
        errors     = 0;
        cycles     = 0;
        max_wait   = 8;
        long_hold  = 1'b0;
        filt_regs[REG_B0]    = 18'd16384;
        filt_regs[REG_B1]    = 18'd0;
        filt_regs[REG_B2]    = 18'd0;
        filt_regs[REG_A0]    = 18'd16384;
        filt_regs[REG_A1]    = 18'd0;
        filt_regs[REG_A2]    = 18'd0;
        filt_regs[REG_GAIN]  = 18'd4096;
        filt_regs[REG_SRATE] = 18'd48000;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_extremes();
        test_backpressure();
        test_random(12, 100);

        drain_results();
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
